// File: hdl/calendar_date_add_days_unit_defines.svh
// Assertion macros shared by the calendar date adder modules.
`ifndef CALENDAR_DATE_ADD_DAYS_UNIT_DEFINES_SVH
`define CALENDAR_DATE_ADD_DAYS_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define CDAD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define CDAD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/cdad_pkg.sv
// Package: types, constants and calendar helper functions of the date adder.
`default_nettype none
package cdad_pkg;

  localparam int unsigned YearW  = 16;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned CountW = 16;

  localparam logic [YearW-1:0]  YearMax   = 16'hFFFF;
  localparam logic [MonthW-1:0] MonthJan  = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb  = 4'd2;
  localparam logic [MonthW-1:0] MonthDec  = 4'd12;
  localparam logic [DayW-1:0]   DayFirst  = 5'd1;
  localparam logic [DayW-1:0]   DayLast   = 5'd31;
  localparam logic [DayW-1:0]   FebLeap   = 5'd29;
  localparam logic [DayW-1:0]   FebCommon = 5'd28;

  // Divisibility by 25 via the modular inverse: y*inv mod 2^16 <= floor(65535/25)
  localparam logic [YearW-1:0] Inv25   = 16'd23593;
  localparam logic [YearW-1:0] Lim25   = 16'd2621;

  localparam logic [DayW-1:0] MonthLenTab [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_BAD_SET = 2'd1,
    STS_OVF     = 2'd2
  } cdad_status_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;    // latch the incoming word
    logic set_check;  // validate and load a set word
    logic add_step;   // consume one month of the count
    logic load_out;   // copy the date into the output register
  } cdad_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic step_done;  // the current add step finishes the item
  } cdad_sts_t;

  // Gregorian leap rule: divisible by 4 and not by 100, or by 400.
  // 100 = 4*25 and 400 = 16*25, so one divisibility test by 25 suffices.
  function automatic logic is_leap(input logic [YearW-1:0] y);
    logic [2*YearW-1:0] full;
    logic               div25;
    full  = (2*YearW)'(y) * (2*YearW)'(Inv25);
    div25 = (full[YearW-1:0] <= Lim25);
    return ((y[1:0] == 2'b00) && !div25) || ((y[3:0] == 4'b0000) && div25);
  endfunction

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic leap);
    logic [DayW-1:0] len;
    if (m == MonthFeb) begin
      len = leap ? FebLeap : FebCommon;
    end else if (m >= MonthJan && m <= MonthDec) begin
      len = MonthLenTab[4'(m - MonthJan)];
    end else begin
      len = DayLast;
    end
    return len;
  endfunction

endpackage
`default_nettype wire

// File: hdl/cdad_in_if.sv
// Input channel: one set or add word with valid/ready handshake.
`default_nettype none
interface cdad_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [15:0] new_year;
  logic [3:0]  new_month;
  logic [4:0]  new_day;
  logic [15:0] day_count;

  modport source (output valid, command, new_year, new_month, new_day, day_count,
                  input ready);
  modport sink   (input valid, command, new_year, new_month, new_day, day_count,
                  output ready);
endinterface
`default_nettype wire

// File: hdl/cdad_out_if.sv
// Output channel: current date and status word with valid/ready handshake.
`default_nettype none
interface cdad_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [1:0]  status;

  modport source (output valid, year, month, day, status, input ready);
  modport sink   (input valid, year, month, day, status, output ready);
endinterface
`default_nettype wire

// File: hdl/cdad_ctrl.sv
// Controller: sequences set checks and month-by-month add steps.
`default_nettype none
`include "calendar_date_add_days_unit_defines.svh"
module cdad_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_command_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output cdad_pkg::cdad_cmd_t    cmd_o,
  input  wire cdad_pkg::cdad_sts_t sts_i
);
  import cdad_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SET_LEAP,
    ST_SET_CHECK,
    ST_ADD_STEP,
    ST_RESULT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   accept;
  logic   out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  // Datapath commands decoded from state
  always_comb begin
    cmd_o           = '0;
    cmd_o.capture   = accept;
    cmd_o.set_check = (state_q == ST_SET_CHECK);
    cmd_o.add_step  = (state_q == ST_ADD_STEP);
    cmd_o.load_out  = (state_q == ST_RESULT) && out_free;
  end

  // State and output-valid register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      // raised as a result is loaded, dropped once the word is taken
      if ((state_q == ST_RESULT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= in_command_i ? ST_ADD_STEP : ST_SET_LEAP;
          end
        end
        ST_SET_LEAP: begin
          // leap flag of the new year settles here
          state_q <= ST_SET_CHECK;
        end
        ST_SET_CHECK: begin
          state_q <= ST_RESULT;
        end
        ST_ADD_STEP: begin
          if (sts_i.step_done) begin
            state_q <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  `CDAD_ASSERT_NEXT(a_step_holds, clk_i, rst_ni,
                    (state_q == ST_ADD_STEP) && !sts_i.step_done,
                    state_q == ST_ADD_STEP, "add step left before done")
  `CDAD_ASSERT_NOW(a_load_free, clk_i, rst_ni, cmd_o.load_out,
                   !out_valid_q || out_ready_i, "output register overwritten")
  `CDAD_ASSERT_NEXT(a_result_issued, clk_i, rst_ni, (state_q == ST_RESULT) && out_free,
                    (state_q == ST_IDLE) && out_valid_q, "result word not issued")

endmodule
`default_nettype wire

// File: hdl/cdad_dpath.sv
// Datapath: date registers, leap flags, month-length table and output register.
`default_nettype none
`include "calendar_date_add_days_unit_defines.svh"
module cdad_dpath (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cdad_pkg::cdad_cmd_t  cmd_i,
  output cdad_pkg::cdad_sts_t       sts_o,
  input  wire logic [15:0]          new_year_i,
  input  wire logic [3:0]           new_month_i,
  input  wire logic [4:0]           new_day_i,
  input  wire logic [15:0]          day_count_i,
  output logic [15:0]               year_o,
  output logic [3:0]                month_o,
  output logic [4:0]                day_o,
  output logic [1:0]                status_o
);
  import cdad_pkg::*;

  // Captured word
  logic [YearW-1:0]  item_year_q;
  logic [MonthW-1:0] item_month_q;
  logic [DayW-1:0]   item_day_q;

  // Current date and working count
  logic [YearW-1:0]  cur_year_q,  cur_year_d;
  logic [MonthW-1:0] cur_month_q, cur_month_d;
  logic [DayW-1:0]   cur_day_q,   cur_day_d;
  logic [CountW-1:0] left_q,      left_d;
  cdad_status_e      status_q,    status_d;

  // Leap flags: current year, following year, and the word's year
  logic leap_cur_q, leap_cur_d;
  logic leap_nxt_q;
  logic leap_new_q;

  // Output register
  logic [YearW-1:0]  out_year_q;
  logic [MonthW-1:0] out_month_q;
  logic [DayW-1:0]   out_day_q;
  cdad_status_e      out_status_q;

  logic [DayW-1:0]   len;
  logic [CountW:0]   sum;
  logic              fits;
  logic              at_end;
  logic [DayW-1:0]   span;
  logic [DayW-1:0]   new_len;
  logic              set_ok;

  // One month of the add
  assign len    = month_len(cur_month_q, leap_cur_q);
  assign sum    = (CountW+1)'(cur_day_q) + (CountW+1)'(left_q);
  assign fits   = (sum <= (CountW+1)'(len));
  assign at_end = (cur_month_q == MonthDec) && (cur_year_q == YearMax);
  assign span   = DayW'(len - cur_day_q) + DayFirst;

  assign sts_o.step_done = fits || at_end;

  // Set word check against the new year's calendar
  assign new_len = month_len(item_month_q, leap_new_q);
  always_comb begin
    set_ok = (item_month_q inside {[MonthJan:MonthDec]}) &&
             (item_day_q != '0) && (item_day_q <= new_len);
  end

  // Next state of the date
  always_comb begin
    cur_year_d  = cur_year_q;
    cur_month_d = cur_month_q;
    cur_day_d   = cur_day_q;
    left_d      = left_q;
    status_d    = status_q;
    leap_cur_d  = leap_cur_q;
    if (cmd_i.capture) begin
      left_d   = day_count_i;
      status_d = STS_OK;
    end else if (cmd_i.set_check) begin
      if (set_ok) begin
        cur_year_d  = item_year_q;
        cur_month_d = item_month_q;
        cur_day_d   = item_day_q;
        leap_cur_d  = leap_new_q;
      end else begin
        status_d = STS_BAD_SET;
      end
    end else if (cmd_i.add_step) begin
      if (fits) begin
        cur_day_d = sum[DayW-1:0];
      end else begin
        left_d    = left_q - CountW'(span);
        cur_day_d = DayFirst;
        if (cur_month_q == MonthDec) begin
          if (cur_year_q == YearMax) begin
            // saturate at the last representable date
            cur_day_d = DayLast;
            status_d  = STS_OVF;
          end else begin
            cur_year_d  = cur_year_q + 1'b1;
            cur_month_d = MonthJan;
            leap_cur_d  = leap_nxt_q;
          end
        end else begin
          cur_month_d = cur_month_q + 1'b1;
        end
      end
    end
  end

  // Date and flag registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_year_q  <= YearW'(1);
      cur_month_q <= MonthJan;
      cur_day_q   <= DayFirst;
      leap_cur_q  <= 1'b0;
      leap_nxt_q  <= 1'b0;
      status_q    <= STS_OK;
    end else begin
      cur_year_q  <= cur_year_d;
      cur_month_q <= cur_month_d;
      cur_day_q   <= cur_day_d;
      leap_cur_q  <= leap_cur_d;
      status_q    <= status_d;
      // next year's flag, ready long before the year rolls over
      leap_nxt_q  <= is_leap(cur_year_q + 1'b1);
    end
  end

  // Word capture, working count and output register
  always_ff @(posedge clk_i) begin
    left_q     <= left_d;
    leap_new_q <= is_leap(item_year_q);
    if (cmd_i.capture) begin
      item_year_q  <= new_year_i;
      item_month_q <= new_month_i;
      item_day_q   <= new_day_i;
    end
    if (cmd_i.load_out) begin
      out_year_q   <= cur_year_q;
      out_month_q  <= cur_month_q;
      out_day_q    <= cur_day_q;
      out_status_q <= status_q;
    end
  end

  assign year_o   = out_year_q;
  assign month_o  = out_month_q;
  assign day_o    = out_day_q;
  assign status_o = out_status_q;

  `CDAD_ASSERT_NOW(a_date_valid, clk_i, rst_ni, 1'b1, (cur_month_q >= MonthJan) && (cur_month_q <= MonthDec) && (cur_day_q != '0) && (cur_day_q <= month_len(cur_month_q, leap_cur_q)), "held date out of range")
  `CDAD_ASSERT_NOW(a_leap_track, clk_i, rst_ni, 1'b1, leap_cur_q == is_leap(cur_year_q), "leap flag out of step with year")
  `CDAD_ASSERT_NOW(a_sat_date, clk_i, rst_ni, status_q == STS_OVF, (cur_year_q == YearMax) && (cur_month_q == MonthDec) && (cur_day_q == DayLast), "overflow without saturated date")

endmodule
`default_nettype wire

// File: hdl/calendar_date_add_days_unit.sv
// Top level of the calendar date adder: controller, datapath and channel wiring.
//
// Usage: words arrive on req_i (valid/ready). command 0 loads new_year,
// new_month and new_day after a Gregorian range check; command 1 advances
// the held date by day_count days. Each accepted word yields exactly one
// word on rsp_o: the date after the operation and a status (0 ok, 1 set
// refused and date kept, 2 add saturated at 65535-12-31).
// A set passes a leap state and a check state before its result is
// loaded. An add walks one month per cycle through the month-length
// table; 65535 days cross at most about 2154 months.
// A new word is taken once the previous one has reached the output
// register; that register holds a result while rsp_o is stalled, so the
// next word is accepted and worked on, and the block waits only when a
// second result is ready before the first has been taken.
// Reset (asynchronous, active low) sets the date to 0001-01-01, clears
// rsp_o valid and returns the controller to idle, ready for a word.
`default_nettype none
module calendar_date_add_days_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cdad_in_if.sink   req_i,
  cdad_out_if.source rsp_o
);
  import cdad_pkg::*;

  cdad_cmd_t cmd;
  cdad_sts_t sts;

  cdad_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (req_i.valid),
    .in_command_i (req_i.command),
    .in_ready_o   (req_i.ready),
    .out_valid_o  (rsp_o.valid),
    .out_ready_i  (rsp_o.ready),
    .cmd_o        (cmd),
    .sts_i        (sts)
  );

  cdad_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .new_year_i  (req_i.new_year),
    .new_month_i (req_i.new_month),
    .new_day_i   (req_i.new_day),
    .day_count_i (req_i.day_count),
    .year_o      (rsp_o.year),
    .month_o     (rsp_o.month),
    .day_o       (rsp_o.day),
    .status_o    (rsp_o.status)
  );

endmodule
`default_nettype wire

// File: verif/cdad_tb_pkg.sv
// Command codes shared by the date adder checker and its testbench top.
`timescale 1ns / 1ps
package cdad_tb_pkg;

  localparam logic CmdSet = 1'b0;  // load a date from the word's fields
  localparam logic CmdAdd = 1'b1;  // advance the held date by day_count

endpackage

// File: verif/cdad_date_checker.sv
// Checker: watches both channels, predicts each date word and compares the results.
`timescale 1ns / 1ps
module cdad_date_checker (
  input  logic clk_i,
  input  logic rst_ni,
  cdad_in_if   req_i,
  cdad_out_if  rsp_i,
  output int   errors_o,
  output int   pending_o
);
  import cdad_pkg::*;
  import cdad_tb_pkg::*;

  typedef struct {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    cdad_status_e      status;
  } date_word_t;

  // Predicted calendar state
  int unsigned cal_year;
  int unsigned cal_month;
  int unsigned cal_day;

  date_word_t expected_dates_q[$];

  // Month length under the full Gregorian leap rule
  function automatic int unsigned days_in(input int unsigned y, input int unsigned m);
    bit leap;
    leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    case (m)
      2: begin
        return leap ? 29 : 28;
      end
      4, 6, 9, 11: begin
        return 30;
      end
      default: begin
        return 31;
      end
    endcase
  endfunction

  // Apply one accepted word to the held date and return the expected result
  function automatic date_word_t next_date(input logic cmd, input logic [15:0] y,
                                           input logic [3:0] m, input logic [4:0] d,
                                           input logic [15:0] cnt);
    date_word_t  w;
    int unsigned left;
    int unsigned len;
    bit          done;
    w.status = STS_OK;
    if (cmd == CmdSet) begin
      if (m >= 1 && m <= 12 && d >= 1 && d <= days_in(y, m)) begin
        cal_year  = y;
        cal_month = m;
        cal_day   = d;
      end else begin
        w.status = STS_BAD_SET;
      end
    end else begin
      left = cnt;
      done = 1'b0;
      // walk month by month; saturate at the last day of the largest year
      while (!done) begin
        len = days_in(cal_year, cal_month);
        if (cal_day + left <= len) begin
          cal_day += left;
          done = 1'b1;
        end else begin
          left -= len - cal_day + 1;
          if (cal_month >= 12) begin
            if (cal_year >= YearMax) begin
              cal_year  = YearMax;
              cal_month = 12;
              cal_day   = 31;
              w.status  = STS_OVF;
              done      = 1'b1;
            end else begin
              cal_year  += 1;
              cal_month = 1;
              cal_day   = 1;
            end
          end else begin
            cal_month += 1;
            cal_day   = 1;
          end
        end
      end
    end
    w.year  = YearW'(cal_year);
    w.month = MonthW'(cal_month);
    w.day   = DayW'(cal_day);
    return w;
  endfunction

  // Results are compared before the same edge's input is predicted
  always @(posedge clk_i or negedge rst_ni) begin : watch_b
    date_word_t exp_w;
    if (!rst_ni) begin
      cal_year  = 1;
      cal_month = 1;
      cal_day   = 1;
      expected_dates_q.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (expected_dates_q.size() == 0) begin
          $error("unexpected result word %0d-%0d-%0d status %0d",
                 rsp_i.year, rsp_i.month, rsp_i.day, rsp_i.status);
          errors_o++;
        end else begin
          exp_w = expected_dates_q.pop_front();
          if (rsp_i.year !== exp_w.year) begin
            $error("year: expected %0d, got %0d", exp_w.year, rsp_i.year);
            errors_o++;
          end
          if (rsp_i.month !== exp_w.month) begin
            $error("month: expected %0d, got %0d", exp_w.month, rsp_i.month);
            errors_o++;
          end
          if (rsp_i.day !== exp_w.day) begin
            $error("day: expected %0d, got %0d", exp_w.day, rsp_i.day);
            errors_o++;
          end
          if (rsp_i.status !== exp_w.status) begin
            $error("status: expected %0d, got %0d", exp_w.status, rsp_i.status);
            errors_o++;
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        expected_dates_q.push_back(next_date(req_i.command, req_i.new_year,
                                             req_i.new_month, req_i.new_day,
                                             req_i.day_count));
      end
      pending_o = expected_dates_q.size();
    end
  end

endmodule

// File: verif/calendar_date_add_days_unit_test.sv
// Testbench top: clock, reset, date word stimulus, idling phases and the verdict.
`timescale 1ns / 1ps
module calendar_date_add_days_unit_test;
  import cdad_pkg::*;
  import cdad_tb_pkg::*;

  localparam int HalfPeriod = 6;
  localparam int QuietLimit = 30000;  // longest add plus long stalls, several times over
  localparam int PhaseWords = 61;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  int idle_pct     = 0;
  int stall_pct    = 0;
  int quiet_cycles = 0;
  int errors;
  int pending;

  cdad_in_if  req_if ();
  cdad_out_if rsp_if ();

  calendar_date_add_days_unit dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  cdad_date_checker date_chk (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .req_i    (req_if),
    .rsp_i    (rsp_if),
    .errors_o (errors),
    .pending_o(pending)
  );

  always #HalfPeriod clk = ~clk;

  // Receiver back-pressure
  always @(negedge clk) begin
    rsp_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("Some tests failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(input logic cmd, input logic [15:0] y, input logic [3:0] m,
                           input logic [4:0] d, input logic [15:0] cnt);
    while ($urandom_range(99) < idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.command   <= cmd;
    req_if.new_year  <= y;
    req_if.new_month <= m;
    req_if.new_day   <= d;
    req_if.day_count <= cnt;
    do @(posedge clk); while (!req_if.ready);
    @(negedge clk);
  endtask

  // day_count carries noise on a set, the date fields on an add
  task automatic set_date(input logic [15:0] y, input logic [3:0] m, input logic [4:0] d);
    send_word(CmdSet, y, m, d, 16'($urandom));
  endtask

  task automatic add_days(input logic [15:0] cnt);
    send_word(CmdAdd, 16'($urandom), 4'($urandom), 5'($urandom), cnt);
  endtask

  // Mostly plausible dates and short counts; a few full-range counts
  task automatic random_word();
    int          roll;
    int          sel;
    logic [15:0] y;
    logic [3:0]  m;
    logic [4:0]  d;
    roll = $urandom_range(99);
    sel  = $urandom_range(99);
    if (roll < 40) begin
      if (sel < 10) begin
        y = 16'($urandom_range(65530, 65535));
      end else if (sel < 25) begin
        y = 16'(100 * $urandom_range(0, 655));
      end else begin
        y = 16'($urandom);
      end
      sel = $urandom_range(99);
      if (sel < 15) begin
        m = 4'($urandom);
        d = 5'($urandom);
      end else begin
        m = 4'($urandom_range(1, 12));
        d = (sel < 60) ? 5'($urandom_range(1, 28)) : 5'($urandom_range(1, 31));
      end
      set_date(y, m, d);
    end else if (sel < 70) begin
      add_days(16'($urandom_range(0, 60)));
    end else if (sel < 90) begin
      add_days(16'($urandom_range(0, 1500)));
    end else begin
      add_days(16'($urandom));
    end
  endtask

  initial begin
    req_if.valid     = 1'b0;
    req_if.command   = CmdSet;
    req_if.new_year  = '0;
    req_if.new_month = '0;
    req_if.new_day   = '0;
    req_if.day_count = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: zero count, ignored fields, leap rules, bad sets, saturation
    add_days(16'd0);
    send_word(CmdAdd, 16'h0000, 4'h0, 5'h00, 16'd1);
    send_word(CmdAdd, 16'hFFFF, 4'hF, 5'h1F, 16'd30);
    set_date(16'd2000, 4'd2, 5'd29);
    set_date(16'd1900, 4'd2, 5'd29);
    set_date(16'd2024, 4'd2, 5'd29);
    set_date(16'd2023, 4'd2, 5'd29);
    set_date(16'd2023, 4'd0, 5'd1);
    set_date(16'd2023, 4'd13, 5'd1);
    set_date(16'd2023, 4'd15, 5'd31);
    set_date(16'd2023, 4'd4, 5'd0);
    set_date(16'd2023, 4'd4, 5'd31);
    set_date(16'd0, 4'd1, 5'd31);
    add_days(16'hFFFF);
    set_date(YearMax, 4'd12, 5'd31);
    add_days(16'd1);
    add_days(16'd0);
    set_date(YearMax, 4'd12, 5'd30);
    add_days(16'd1);
    set_date(YearMax, 4'd1, 5'd1);
    add_days(16'hFFFF);
    send_word(CmdSet, 16'hFFFF, 4'd12, 5'd31, 16'hFFFF);
    set_date(16'd1999, 4'd12, 5'd31);
    add_days(16'd60);
    set_date(16'd2100, 4'd2, 5'd28);
    add_days(16'd1);

    // Random words over the idling phases
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 83;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 83;
        end
        default: begin
          idle_pct  = 36;
          stall_pct = 36;
        end
      endcase
      repeat (PhaseWords) random_word();
    end
    req_if.valid <= 1'b0;

    // Drain, then settle
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
